/* rtl/srp_pkg.sv */
// ----------------------------------------------------------------------------
// srp_pkg - shared types and constants for the rect-to-polar power core
// Field widths, item classes, CORDIC angle table and iteration counts.
// ----------------------------------------------------------------------------
package srp_pkg;

	localparam int SAMPLE_BITS     = 24;
	localparam int PHASE_FRAC_BITS = 13;

	localparam int PHASE_BITS  = PHASE_FRAC_BITS + 3;
	localparam int POWER_BITS  = 2 * SAMPLE_BITS;
	localparam int TOTAL_BITS  = 64;

	localparam int IN_FIELDS_W  = 2 * SAMPLE_BITS;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = SAMPLE_BITS + PHASE_BITS + POWER_BITS + TOTAL_BITS;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int ANGLE_FRAC    = 24;
	localparam int GUARD_BITS    = 24;
	localparam int CORDIC_STEPS  = 24;
	localparam int ANGLE_PI      = 52707179;
	localparam int ANGLE_HALF_PI = 26353589;

	localparam int XW = SAMPLE_BITS + GUARD_BITS + 4;
	localparam int ZW = 28;

	localparam int SQRT_STEPS = SAMPLE_BITS;
	localparam int RUN_STEPS  = (SQRT_STEPS > CORDIC_STEPS) ? SQRT_STEPS : CORDIC_STEPS;
	localparam int CNT_W      = $clog2(RUN_STEPS);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CLS_W = 3;
	localparam logic [CLS_W-1:0] CLS_ZERO     = 3'd0;
	localparam logic [CLS_W-1:0] CLS_PI       = 3'd1;
	localparam logic [CLS_W-1:0] CLS_HALF_PI  = 3'd2;
	localparam logic [CLS_W-1:0] CLS_NHALF_PI = 3'd3;
	localparam logic [CLS_W-1:0] CLS_CORDIC   = 3'd4;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] re;
		logic signed [SAMPLE_BITS-1:0] im;
		logic [POWER_BITS-1:0]         power;
		logic                          last;
		logic [CLS_W-1:0]              cls;
	} srp_item_t;

	function automatic logic signed [ZW-1:0] atan_q24(input logic [CNT_W-1:0] idx);
		logic signed [ZW-1:0] v;
		case (idx)
			5'd0:    v = ZW'(13176795);
			5'd1:    v = ZW'(7778716);
			5'd2:    v = ZW'(4110060);
			5'd3:    v = ZW'(2086331);
			5'd4:    v = ZW'(1047214);
			5'd5:    v = ZW'(524117);
			5'd6:    v = ZW'(262123);
			5'd7:    v = ZW'(131069);
			5'd8:    v = ZW'(65536);
			5'd9:    v = ZW'(32768);
			5'd10:   v = ZW'(16384);
			5'd11:   v = ZW'(8192);
			5'd12:   v = ZW'(4096);
			5'd13:   v = ZW'(2048);
			5'd14:   v = ZW'(1024);
			5'd15:   v = ZW'(512);
			5'd16:   v = ZW'(256);
			5'd17:   v = ZW'(128);
			5'd18:   v = ZW'(64);
			5'd19:   v = ZW'(32);
			5'd20:   v = ZW'(16);
			5'd21:   v = ZW'(8);
			5'd22:   v = ZW'(4);
			5'd23:   v = ZW'(2);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* rtl/srp_front.sv */
// ----------------------------------------------------------------------------
// srp_front - bin intake and classification
// Registers each bin, squares both parts, sorts the bin into a phase class
// and pushes the finished item into the queue.
// ----------------------------------------------------------------------------
module srp_front import srp_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] in_re,
	input  logic signed [SAMPLE_BITS-1:0] in_im,
	input  logic                          in_real_only,
	input  logic                          in_last,
	output logic                          q_valid,
	input  logic                          q_ready,
	output srp_item_t                     q_item
);

	logic                          v_s1;
	logic signed [SAMPLE_BITS-1:0] re_s1;
	logic signed [SAMPLE_BITS-1:0] im_s1;
	logic                          last_s1;

	logic                          v_s2;
	logic signed [SAMPLE_BITS-1:0] re_s2;
	logic signed [SAMPLE_BITS-1:0] im_s2;
	logic [POWER_BITS-1:0]         sq_re_s2;
	logic [POWER_BITS-1:0]         sq_im_s2;
	logic                          last_s2;
	logic [CLS_W-1:0]              cls_s2;

	logic                          push;
	logic                          load_s2;
	logic signed [POWER_BITS-1:0]  sq_re;
	logic signed [POWER_BITS-1:0]  sq_im;
	logic [CLS_W-1:0]              cls;

	assign push     = v_s2 && q_ready;
	assign load_s2  = v_s1 && (!v_s2 || push);
	assign in_ready = !v_s1 || load_s2;

	assign sq_re = re_s1 * re_s1;
	assign sq_im = im_s1 * im_s1;

	always_comb begin
		if (im_s1 == '0) begin
			cls = re_s1[SAMPLE_BITS-1] ? CLS_PI : CLS_ZERO;
		end else if (re_s1 == '0) begin
			cls = im_s1[SAMPLE_BITS-1] ? CLS_NHALF_PI : CLS_HALF_PI;
		end else begin
			cls = CLS_CORDIC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (load_s2) begin
				v_s2 <= 1'b1;
			end else if (push) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			re_s1   <= in_re;
			im_s1   <= in_real_only ? '0 : in_im;
			last_s1 <= in_last;
		end
		if (load_s2) begin
			re_s2    <= re_s1;
			im_s2    <= im_s1;
			sq_re_s2 <= POWER_BITS'(sq_re);
			sq_im_s2 <= POWER_BITS'(sq_im);
			last_s2  <= last_s1;
			cls_s2   <= cls;
		end
	end

	assign q_valid      = v_s2;
	assign q_item.re    = re_s2;
	assign q_item.im    = im_s2;
	assign q_item.power = sq_re_s2 + sq_im_s2;
	assign q_item.last  = last_s2;
	assign q_item.cls   = cls_s2;

endmodule

/* rtl/srp_queue.sv */
// ----------------------------------------------------------------------------
// srp_queue - short item queue between front and back
// Register-based FIFO of classified items.
// ----------------------------------------------------------------------------
module srp_queue import srp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_valid,
	output logic      wr_ready,
	input  srp_item_t wr_item,
	output logic      rd_valid,
	input  logic      rd_ready,
	output srp_item_t rd_item
);

	srp_item_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign wr_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;
	assign rd_item  = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] n;
		n = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

/* rtl/srp_back.sv */
// ----------------------------------------------------------------------------
// srp_back - iterative CORDIC, square root and frame power sum
// Runs a vectoring CORDIC and a restoring square root side by side, one step
// a cycle, then rounds, updates the saturating sum and fills the output
// register.
// ----------------------------------------------------------------------------
module srp_back import srp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	output logic                   q_ready,
	input  srp_item_t              q_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SAMPLE_BITS-1:0] out_magnitude,
	output logic [PHASE_BITS-1:0]  out_phase,
	output logic [POWER_BITS-1:0]  out_bin_power,
	output logic [TOTAL_BITS-1:0]  out_power_total,
	output logic                   out_frame_end
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	localparam int SH = ANGLE_FRAC - PHASE_FRAC_BITS;
	localparam logic signed [ZW-1:0] Z_PI    = ZW'(ANGLE_PI);
	localparam logic signed [ZW-1:0] Z_HALF  = ZW'(ANGLE_HALF_PI);
	localparam logic signed [ZW-1:0] Z_RND   = ZW'(1 << (SH - 1));
	localparam logic signed [ZW-1:0] Z_LIM   = ZW'((ANGLE_PI + (1 << (SH - 1))) >> SH);

	logic [1:0]                 state_q;
	logic [CNT_W-1:0]           cnt_q;

	logic signed [XW-1:0]       x_q;
	logic signed [XW-1:0]       y_q;
	logic signed [ZW-1:0]       z_q;

	logic [POWER_BITS-1:0]      rad_q;
	logic [SAMPLE_BITS+1:0]     rem_q;
	logic [SAMPLE_BITS-1:0]     root_q;

	logic [POWER_BITS-1:0]      power_q;
	logic                       last_q;
	logic [CLS_W-1:0]           cls_q;

	logic [TOTAL_BITS-1:0]      acc_q;

	logic                       out_valid_q;
	logic [SAMPLE_BITS-1:0]     mag_q;
	logic [PHASE_BITS-1:0]      phase_q;
	logic [POWER_BITS-1:0]      bin_power_q;
	logic [TOTAL_BITS-1:0]      total_q;
	logic                       frame_end_q;

	logic                       pop;
	logic                       out_free;
	logic                       finish;

	logic signed [XW-1:0]       x_ld;
	logic signed [XW-1:0]       y_ld;
	logic signed [ZW-1:0]       z_ld;

	logic signed [XW-1:0]       dx;
	logic signed [XW-1:0]       dy;
	logic signed [ZW-1:0]       tz;

	logic [SAMPLE_BITS+3:0]     sq_lhs;
	logic [SAMPLE_BITS+3:0]     sq_rhs;
	logic                       sq_ok;

	logic [SAMPLE_BITS-1:0]     mag;
	logic signed [ZW-1:0]       z_sel;
	logic signed [ZW-1:0]       z_rnd;
	logic signed [ZW-1:0]       z_clp;
	logic [TOTAL_BITS:0]        sum;
	logic [TOTAL_BITS-1:0]      total;

	assign pop      = (state_q == ST_IDLE) && q_valid;
	assign q_ready  = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign finish   = (state_q == ST_FIN) && out_free;

	always_comb begin
		x_ld = signed'(XW'(q_item.re)) <<< GUARD_BITS;
		y_ld = signed'(XW'(q_item.im)) <<< GUARD_BITS;
		z_ld = '0;
		if (q_item.re[SAMPLE_BITS-1]) begin
			x_ld = -x_ld;
			y_ld = -y_ld;
			z_ld = q_item.im[SAMPLE_BITS-1] ? -Z_PI : Z_PI;
		end
	end

	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;
	assign tz = atan_q24(cnt_q);

	assign sq_lhs = {rem_q, rad_q[POWER_BITS-1 -: 2]};
	assign sq_rhs = {2'b00, root_q, 2'b01};
	assign sq_ok  = (sq_lhs >= sq_rhs);

	assign mag = (rem_q > {2'b00, root_q}) ? root_q + 1'b1 : root_q;

	always_comb begin
		case (cls_q)
			CLS_ZERO:     z_sel = '0;
			CLS_PI:       z_sel = Z_PI;
			CLS_HALF_PI:  z_sel = Z_HALF;
			CLS_NHALF_PI: z_sel = -Z_HALF;
			CLS_CORDIC:   z_sel = z_q;
			default:      z_sel = '0;
		endcase
		z_rnd = (z_sel + Z_RND) >>> SH;
		if (z_rnd > Z_LIM) begin
			z_clp = Z_LIM;
		end else if (z_rnd < -Z_LIM) begin
			z_clp = -Z_LIM;
		end else begin
			z_clp = z_rnd;
		end
	end

	assign sum   = {1'b0, acc_q} + (TOTAL_BITS + 1)'(power_q);
	assign total = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (q_valid) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cnt_q == CNT_W'(RUN_STEPS - 1)) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						acc_q   <= last_q ? '0 : total;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_q     <= x_ld;
			y_q     <= y_ld;
			z_q     <= z_ld;
			rad_q   <= q_item.power;
			rem_q   <= '0;
			root_q  <= '0;
			power_q <= q_item.power;
			last_q  <= q_item.last;
			cls_q   <= q_item.cls;
		end else if (state_q == ST_RUN) begin
			if (cnt_q < CNT_W'(CORDIC_STEPS)) begin
				if (!y_q[XW-1]) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + tz;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - tz;
				end
			end
			if (cnt_q < CNT_W'(SQRT_STEPS)) begin
				rad_q  <= rad_q << 2;
				rem_q  <= sq_ok ? (SAMPLE_BITS + 2)'(sq_lhs - sq_rhs)
				                : (SAMPLE_BITS + 2)'(sq_lhs);
				root_q <= {root_q[SAMPLE_BITS-2:0], sq_ok};
			end
		end
		if (finish) begin
			mag_q       <= mag;
			phase_q     <= PHASE_BITS'(z_clp);
			bin_power_q <= power_q;
			total_q     <= total;
			frame_end_q <= last_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_magnitude   = mag_q;
	assign out_phase       = phase_q;
	assign out_bin_power   = bin_power_q;
	assign out_power_total = total_q;
	assign out_frame_end   = frame_end_q;

endmodule

/* rtl/spectrum_rect_to_polar_power_core.sv */
// ----------------------------------------------------------------------------
// spectrum_rect_to_polar_power_core - spectrum bin to polar form and power
// Magnitude, four-quadrant phase and exact power per bin, with a saturating
// frame power sum given with every result and cleared after the last bin.
//
//   channel  dir  tdata (low bit up)                        tuser      tlast
//   s_       in   real_part[23:0] imag_part[47:24]          real_only  last_bin
//   m_       out  magnitude[23:0] phase[39:24]              -          frame_end
//                 bin_power[87:40] power_total[151:88]
//
// In the back end each bin is loaded, run through 24 shared steps of the
// CORDIC and the square root, then rounded and registered as the result.
// The front end registers each bin in stages s1 and s2 and keeps taking bins
// into a two-entry queue while the back end works or the output stalls.
// Reset clears all control state and the power sum; nothing needs a sweep.
// ----------------------------------------------------------------------------
module spectrum_rect_to_polar_power_core import srp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_TDATA_W-1:0]    s_tdata,   // real_part, imag_part
	input  logic                     s_tuser,   // real_only
	input  logic                     s_tlast,   // last_bin
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_TDATA_W-1:0]   m_tdata,   // magnitude, phase, bin_power, power_total
	output logic                     m_tlast    // frame_end
);

	logic                   q_in_valid;
	logic                   q_in_ready;
	srp_item_t              q_in_item;
	logic                   q_out_valid;
	logic                   q_out_ready;
	srp_item_t              q_out_item;

	logic [SAMPLE_BITS-1:0] magnitude;
	logic [PHASE_BITS-1:0]  phase;
	logic [POWER_BITS-1:0]  bin_power;
	logic [TOTAL_BITS-1:0]  power_total;

	srp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_re        (s_tdata[SAMPLE_BITS-1:0]),
		.in_im        (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.in_real_only (s_tuser),
		.in_last      (s_tlast),
		.q_valid      (q_in_valid),
		.q_ready      (q_in_ready),
		.q_item       (q_in_item)
	);

	srp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (q_in_valid),
		.wr_ready (q_in_ready),
		.wr_item  (q_in_item),
		.rd_valid (q_out_valid),
		.rd_ready (q_out_ready),
		.rd_item  (q_out_item)
	);

	srp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_out_valid),
		.q_ready         (q_out_ready),
		.q_item          (q_out_item),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_magnitude   (magnitude),
		.out_phase       (phase),
		.out_bin_power   (bin_power),
		.out_power_total (power_total),
		.out_frame_end   (m_tlast)
	);

	assign m_tdata = OUT_TDATA_W'({power_total, bin_power, phase, magnitude});

endmodule
